FILE: sv/tfmu_pkg.sv
// Shared types, codes and sizing constants of the TLB map and unmap core.
package tfmu_pkg;

    // Default sizing of the core.
    localparam int TLB_SLOTS_DEF     = 8;
    localparam int VPAGE_BITS_DEF    = 8;
    localparam int FRAME_BITS_DEF    = 8;
    localparam int PROCESS_COUNT_DEF = 4;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Saturation value of a slot age.
    localparam logic [7:0] AGE_MAX = 8'd255;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_UNMAP  = 2'd1;
    localparam logic [1:0] OP_SWITCH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Codes of the slot_source result field.
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_MATCH = 2'd1;
    localparam logic [1:0] SRC_FREE  = 2'd2;
    localparam logic [1:0] SRC_EVICT = 2'd3;

    // Work kinds after classification in the front part.
    typedef enum logic [1:0] {
        K_MAP,
        K_UNMAP,
        K_SWITCH,
        K_NOP
    } t_kind;

    // States of the back part.
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] virtual_page;
        logic [7:0] physical_frame;
        logic [1:0] new_process;
    } t_in_item;

    typedef struct packed {
        logic [1:0] current_process;
        logic [2:0] slot_index;
        logic       slot_touched;
        logic [1:0] slot_source;
    } t_out_item;

    // Classified work item passed through the queue.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] page;
        logic [7:0] frame;
        logic [1:0] proc;
    } t_work;

endpackage

FILE: sv/tfmu_front.sv
// Front part: accepts input transactions, masks and classifies them, and feeds the queue.
module tfmu_front
    import tfmu_pkg::*;
#(
    parameter int VPAGE_BITS    = VPAGE_BITS_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_clearing,
    input  logic     i_q_full,
    output logic     o_push,
    output t_work    o_work
);

    localparam logic [7:0] PAGE_MASK  = 8'((9'd1 << VPAGE_BITS) - 9'd1);
    localparam logic [7:0] FRAME_MASK = 8'((9'd1 << FRAME_BITS) - 9'd1);

    logic  r_valid, n_valid;
    t_work r_work, n_work;
    logic  accept;

    assign o_stall = i_clearing || (r_valid && i_q_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_work  = r_work;

    always_comb begin
        n_work.page  = i_item.virtual_page & PAGE_MASK;
        n_work.frame = i_item.physical_frame & FRAME_MASK;
        n_work.proc  = i_item.new_process;
        unique case (i_item.operation)
            OP_MAP:    n_work.kind = K_MAP;
            OP_UNMAP:  n_work.kind = K_UNMAP;
            // A switch to a process id that does not exist changes nothing.
            OP_SWITCH: n_work.kind = (32'(i_item.new_process) < PROCESS_COUNT) ? K_SWITCH : K_NOP;
            OP_NONE:   n_work.kind = K_NOP;
            default:   n_work.kind = K_NOP;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

FILE: sv/tfmu_queue.sv
// Short queue of classified work items between the front and back parts.
module tfmu_queue
    import tfmu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_work o_work
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work             r_cells [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_cells[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_cells[r_wr_ptr] <= i_work;
        end
    end

endmodule

FILE: sv/tfmu_back.sv
// Back part: TLB slots, page table memory, current process and the result register.
module tfmu_back
    import tfmu_pkg::*;
#(
    parameter int TLB_SLOTS     = TLB_SLOTS_DEF,
    parameter int VPAGE_BITS    = VPAGE_BITS_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_work     i_q_work,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int SLOT_W   = $clog2(TLB_SLOTS);
    localparam int PT_DEPTH = PROCESS_COUNT << VPAGE_BITS;
    localparam int PT_AW    = $clog2(PT_DEPTH);

    t_back_state r_state, n_state;

    logic [VPAGE_BITS-1:0] r_tlb_page  [TLB_SLOTS];
    logic [FRAME_BITS-1:0] r_tlb_frame [TLB_SLOTS];
    logic [1:0]            r_tlb_proc  [TLB_SLOTS];
    logic                  r_tlb_valid [TLB_SLOTS];
    logic [7:0]            r_tlb_age   [TLB_SLOTS];

    logic [FRAME_BITS-1:0] r_pt_frame [PT_DEPTH];
    logic                  r_pt_valid [PT_DEPTH];

    logic [PT_AW-1:0] r_clr_addr;
    logic             clr_done;
    logic [1:0]       r_active, n_active;
    t_work            r_work;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic              commit;
    logic              match_found, free_found;
    logic [SLOT_W-1:0] match_idx, free_idx, old_idx, sel_idx;
    logic [7:0]        old_age;
    logic [1:0]        sel_src;
    logic [PT_AW-1:0]  pt_addr;

    assign clr_done   = (r_clr_addr == PT_AW'(PT_DEPTH - 1));
    assign o_clearing = (r_state == BK_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;
    assign pt_addr    = PT_AW'({r_active, r_work.page[VPAGE_BITS-1:0]});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (clr_done)  n_state = BK_IDLE;
            BK_IDLE:  if (i_q_valid) n_state = BK_EXEC;
            BK_EXEC:  if (commit)    n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop  = 1'b0;
        commit = 1'b0;
        unique case (r_state)
            BK_CLEAR: ;
            BK_IDLE:  o_pop  = i_q_valid;
            BK_EXEC:  commit = !r_out_valid || !i_stall;
            default:  ;
        endcase
    end

    // Slot search: first tag match, first free slot, oldest slot.
    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        old_idx     = '0;
        old_age     = r_tlb_age[0];
        for (int i = 0; i < TLB_SLOTS; i++) begin
            if (!match_found && r_tlb_page[i] == r_work.page[VPAGE_BITS-1:0] &&
                r_tlb_proc[i] == r_active && (r_work.kind != K_UNMAP || r_tlb_valid[i])) begin
                match_found = 1'b1;
                match_idx   = SLOT_W'(i);
            end
            if (!free_found && !r_tlb_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (r_tlb_age[i] > old_age) begin
                old_age = r_tlb_age[i];
                old_idx = SLOT_W'(i);
            end
        end
        if (match_found) begin
            sel_idx = match_idx;
            sel_src = SRC_MATCH;
        end else if (free_found) begin
            sel_idx = free_idx;
            sel_src = SRC_FREE;
        end else begin
            sel_idx = old_idx;
            sel_src = SRC_EVICT;
        end
    end

    // Result of the work item in execution.
    always_comb begin
        n_active = r_active;
        n_out    = '0;
        case (r_work.kind)
            K_MAP: begin
                n_out.slot_index   = 3'(sel_idx);
                n_out.slot_touched = 1'b1;
                n_out.slot_source  = sel_src;
            end
            K_UNMAP: begin
                if (match_found) begin
                    n_out.slot_index   = 3'(match_idx);
                    n_out.slot_touched = 1'b1;
                    n_out.slot_source  = SRC_MATCH;
                end
            end
            K_SWITCH: n_active = r_work.proc;
            default: ;
        endcase
        n_out.current_process = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TLB_SLOTS; i++) begin
                r_tlb_page[i]  <= '0;
                r_tlb_frame[i] <= '0;
                r_tlb_proc[i]  <= '0;
                r_tlb_valid[i] <= 1'b0;
                r_tlb_age[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR && !clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (commit && r_work.kind == K_MAP) begin
                // The written slot restarts at age zero; every other valid slot ages.
                for (int i = 0; i < TLB_SLOTS; i++) begin
                    if (SLOT_W'(i) == sel_idx) begin
                        r_tlb_age[i] <= '0;
                    end else if (r_tlb_valid[i] && r_tlb_age[i] != AGE_MAX) begin
                        r_tlb_age[i] <= r_tlb_age[i] + 8'd1;
                    end
                end
                r_tlb_page[sel_idx]  <= r_work.page[VPAGE_BITS-1:0];
                r_tlb_frame[sel_idx] <= r_work.frame[FRAME_BITS-1:0];
                r_tlb_proc[sel_idx]  <= r_active;
                r_tlb_valid[sel_idx] <= 1'b1;
            end
            if (commit && r_work.kind == K_UNMAP && match_found) begin
                r_tlb_valid[match_idx] <= 1'b0;
            end
        end
        if (o_pop) begin
            r_work <= i_q_work;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    // Page table memory: one write port, shared by the clearing pass and by commits.
    always_ff @(posedge i_clk) begin
        if (r_state == BK_CLEAR) begin
            r_pt_frame[r_clr_addr] <= '0;
            r_pt_valid[r_clr_addr] <= 1'b0;
        end else if (commit && r_work.kind == K_MAP) begin
            r_pt_frame[pt_addr] <= r_work.frame[FRAME_BITS-1:0];
            r_pt_valid[pt_addr] <= 1'b1;
        end else if (commit && r_work.kind == K_UNMAP) begin
            r_pt_valid[pt_addr] <= 1'b0;
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> !o_pop)
        else $error("work taken from the queue during the clearing pass");

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BK_EXEC))
        else $error("popped work item did not enter execution");

    a_map_writes_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_work.kind == K_MAP) |=>
        (r_tlb_valid[$past(sel_idx)] && r_tlb_age[$past(sel_idx)] == 8'd0))
        else $error("mapped slot is not valid with age zero");

    a_result_follows_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("commit did not load the result register");

endmodule

FILE: sv/tlb_fifo_map_unmap_core.sv
// Top level of the process-tagged TLB with per-process page table and FIFO replacement.
//
// Input channel: i_in_valid, o_in_stall and the i_in payload carry map, unmap and
// process switch commands; a transaction completes at a rising edge with valid high
// and stall low. Output channel: o_out_valid, i_out_stall and o_out return exactly one
// result transaction per input transaction, in order.
// The front part registers and classifies each command, a two-entry queue decouples
// it from the back part, and the back part searches the slots, updates the TLB and the
// page table and loads the result register.
// From input acceptance to o_out_valid a command passes the front register, the queue,
// the back work register and the result register. The back part takes one command from
// the queue in BK_IDLE and searches and commits it in BK_EXEC before it takes the next.
// After reset the back part clears the page table memory, one entry per cycle, all
// PROCESS_COUNT << VPAGE_BITS entries (1024 by default); o_in_stall is high during that
// pass. The TLB slots, ages and current process reset to zero at once.
// When the receiver stalls, the result stays in the output register; the back part
// holds its next command, and the queue and front part keep accepting until full.
module tlb_fifo_map_unmap_core
    import tfmu_pkg::*;
#(
    parameter int TLB_SLOTS     = TLB_SLOTS_DEF,
    parameter int VPAGE_BITS    = VPAGE_BITS_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // Classified work leaving the front register and entering the queue.
    t_work push_work;
    logic  push;
    logic  q_full;

    // Head of the queue as seen by the back part.
    t_work q_work;
    logic  q_valid;
    logic  pop;

    // High while the page table clearing pass runs.
    logic  clearing;

    tfmu_front #(
        .VPAGE_BITS    (VPAGE_BITS),
        .FRAME_BITS    (FRAME_BITS),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_item     (i_in),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_work     (push_work)
    );

    tfmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    tfmu_back #(
        .TLB_SLOTS     (TLB_SLOTS),
        .VPAGE_BITS    (VPAGE_BITS),
        .FRAME_BITS    (FRAME_BITS),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_work   (q_work),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out)
    );

endmodule

FILE: tb/tlb_fifo_map_unmap_core_test.sv
// Self-checking testbench of the process-tagged TLB map and unmap core.
module tlb_fifo_map_unmap_core_test;
    import tfmu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = TLB_SLOTS_DEF;
    localparam int PT_ENTRIES     = PROCESS_COUNT_DEF << VPAGE_BITS_DEF;
    localparam int PHASE_ITEMS    = 400;
    // Longest quiet stretch allowed: covers the page table clearing pass after reset,
    // the long receiver hold-off and the longest random gaps, with margin.
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_OFF       = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    tlb_fifo_map_unmap_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the TLB slots, the page table and the current process. Every
    // slot starts as page 0 of process 0, invalid, age 0, exactly as after reset.
    logic [7:0] slot_vpage [SLOTS]     = '{default: '0};
    logic [7:0] slot_pframe [SLOTS]    = '{default: '0};
    logic [1:0] slot_pid [SLOTS]       = '{default: '0};
    logic       slot_live [SLOTS]      = '{default: 1'b0};
    logic [7:0] slot_age [SLOTS]       = '{default: '0};
    logic [8:0] pt_entry [PT_ENTRIES]  = '{default: '0};
    logic [1:0] cur_pid                = '0;

    // Results still owed by the core, oldest first.
    t_out_item pending_results [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int op_count [4]  = '{default: 0};
    int evictions     = 0;
    int age_saturated = 0;

    // Receiver behavior: percentage of cycles with stall high, and a hold-off counter
    // that this process counts down on its own once the stimulus loads it.
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int tx_idle_pct  = 0;

    // Directed rows. Rows with a typed expectation check the core against the hand
    // value; the others are checked against the predictor. The predictor runs on
    // every row so that its state follows the core.
    typedef struct packed {
        t_in_item  cmd;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [23] = '{
        // Zeroed slot 0 carries page 0 of process 0, so this map reuses it.
        '{'{OP_MAP,    8'h00, 8'h00, 2'd0}, 1'b1, '{2'd0, 3'd0, 1'b1, SRC_MATCH}},
        // Highest page and frame go to the lowest free slot.
        '{'{OP_MAP,    8'hFF, 8'hFF, 2'd0}, 1'b1, '{2'd0, 3'd1, 1'b1, SRC_FREE}},
        '{'{OP_UNMAP,  8'hFF, 8'h00, 2'd0}, 1'b1, '{2'd0, 3'd1, 1'b1, SRC_MATCH}},
        // A second unmap finds no valid slot and only clears the page table bit.
        '{'{OP_UNMAP,  8'hFF, 8'h00, 2'd0}, 1'b1, '{2'd0, 3'd0, 1'b0, SRC_NONE}},
        // The unused operation code changes nothing.
        '{'{OP_NONE,   8'hFF, 8'hFF, 2'd3}, 1'b1, '{2'd0, 3'd0, 1'b0, SRC_NONE}},
        '{'{OP_SWITCH, 8'h00, 8'h00, 2'd3}, 1'b1, '{2'd3, 3'd0, 1'b0, SRC_NONE}},
        '{'{OP_MAP,    8'h00, 8'hAA, 2'd0}, 1'b0, '0},
        '{'{OP_SWITCH, 8'hFF, 8'hFF, 2'd1}, 1'b1, '{2'd1, 3'd0, 1'b0, SRC_NONE}},
        // Fill the remaining slots in process 1, then force evictions.
        '{'{OP_MAP,    8'h10, 8'h01, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h11, 8'h02, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h12, 8'h04, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h13, 8'h08, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h14, 8'h10, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h15, 8'h20, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h16, 8'h40, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h17, 8'h80, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h10, 8'h5A, 2'd2}, 1'b0, '0},
        '{'{OP_MAP,    8'h20, 8'hA5, 2'd1}, 1'b0, '0},
        '{'{OP_MAP,    8'h21, 8'h3C, 2'd0}, 1'b0, '0},
        '{'{OP_UNMAP,  8'h12, 8'h00, 2'd0}, 1'b0, '0},
        '{'{OP_MAP,    8'h55, 8'hC3, 2'd3}, 1'b0, '0},
        '{'{OP_SWITCH, 8'h00, 8'h00, 2'd0}, 1'b1, '{2'd0, 3'd0, 1'b0, SRC_NONE}},
        '{'{OP_SWITCH, 8'h00, 8'h00, 2'd2}, 1'b1, '{2'd2, 3'd0, 1'b0, SRC_NONE}}
    };

    // Applies one command to the shadow state and returns the result it causes.
    function automatic t_out_item tlb_predict(input t_in_item cmd);
        t_out_item  res;
        int         pick;
        logic [7:0] oldest;
        logic [9:0] pt_at;
        res   = '0;
        pick  = -1;
        pt_at = {cur_pid, cmd.virtual_page};
        case (cmd.operation)
            OP_MAP: begin
                // A tag match wins even on an invalid slot, then the lowest free
                // slot, then the oldest slot with the lowest index on ties.
                res.slot_source = SRC_MATCH;
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && slot_vpage[i] == cmd.virtual_page && slot_pid[i] == cur_pid)
                        pick = i;
                if (pick < 0) begin
                    res.slot_source = SRC_FREE;
                    for (int i = 0; i < SLOTS; i++)
                        if (pick < 0 && !slot_live[i])
                            pick = i;
                end
                if (pick < 0) begin
                    res.slot_source = SRC_EVICT;
                    pick   = 0;
                    oldest = slot_age[0];
                    for (int i = 1; i < SLOTS; i++)
                        if (slot_age[i] > oldest) begin
                            oldest = slot_age[i];
                            pick   = i;
                        end
                    evictions++;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_age[i] != AGE_MAX) begin
                        slot_age[i] = slot_age[i] + 8'd1;
                        if (slot_age[i] == AGE_MAX)
                            age_saturated++;
                    end
                slot_vpage[pick]  = cmd.virtual_page;
                slot_pframe[pick] = cmd.physical_frame;
                slot_pid[pick]    = cur_pid;
                slot_live[pick]   = 1'b1;
                slot_age[pick]    = '0;
                pt_entry[pt_at]   = {cmd.physical_frame, 1'b1};
                res.slot_index    = pick[2:0];
                res.slot_touched  = 1'b1;
            end
            OP_UNMAP: begin
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && slot_live[i] && slot_vpage[i] == cmd.virtual_page &&
                        slot_pid[i] == cur_pid)
                        pick = i;
                if (pick >= 0) begin
                    slot_live[pick]  = 1'b0;
                    res.slot_index   = pick[2:0];
                    res.slot_touched = 1'b1;
                    res.slot_source  = SRC_MATCH;
                end
                pt_entry[pt_at][0] = 1'b0;
            end
            OP_SWITCH: begin
                if (cmd.new_process < PROCESS_COUNT_DEF)
                    cur_pid = cmd.new_process;
            end
            default: begin
            end
        endcase
        res.current_process = cur_pid;
        return res;
    endfunction

    // Random command. Pages come mostly from a small pool so that matches, unmap hits
    // and evictions are frequent; wide_pct of them span the whole page range.
    function automatic t_in_item random_command(input int map_pct, input int unmap_pct,
                                                input int switch_pct, input int span,
                                                input int wide_pct);
        t_in_item cmd;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < map_pct)
            cmd.operation = OP_MAP;
        else if (roll < map_pct + unmap_pct)
            cmd.operation = OP_UNMAP;
        else if (roll < map_pct + unmap_pct + switch_pct)
            cmd.operation = OP_SWITCH;
        else
            cmd.operation = OP_NONE;
        if ($urandom_range(0, 99) < wide_pct)
            cmd.virtual_page = 8'($urandom_range(0, 255));
        else
            cmd.virtual_page = 8'($urandom_range(0, span - 1));
        cmd.physical_frame = 8'($urandom_range(0, 255));
        cmd.new_process    = 2'($urandom_range(0, 3));
        return cmd;
    endfunction

    // Offers one command and holds it steady until the core takes it, then records
    // what the core owes for it.
    task automatic send_command(input t_in_item cmd, input logic typed, input t_out_item want);
        t_out_item predicted;
        i_in       <= cmd;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = tlb_predict(cmd);
        pending_results.push_back(typed ? want : predicted);
        op_count[cmd.operation]++;
    endtask

    // Lets the input side go quiet for a random number of cycles, if the idle draw hits.
    task automatic sender_gap();
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    // Pauses the sender until every owed result has been returned.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stall per cycle, or a solid hold-off while hold_left runs down.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    // Compares every returned transaction against the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing owed: %p", o_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.current_process !== want.current_process) begin
                    $error("current_process: expected %0d, got %0d",
                           want.current_process, o_out.current_process);
                    mismatches++;
                end
                if (o_out.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want.slot_index, o_out.slot_index);
                    mismatches++;
                end
                if (o_out.slot_touched !== want.slot_touched) begin
                    $error("slot_touched: expected %0d, got %0d",
                           want.slot_touched, o_out.slot_touched);
                    mismatches++;
                end
                if (o_out.slot_source !== want.slot_source) begin
                    $error("slot_source: expected %0d, got %0d",
                           want.slot_source, o_out.slot_source);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a transaction for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results owed",
                     quiet_cycles, pending_results.size());
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in_item cmd;
        int       map_pct;
        int       unmap_pct;
        int       switch_pct;
        int       span;
        int       wide_pct;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back. The core stalls its input during the page
        // table clearing pass, which the handshake absorbs.
        foreach (DIRECTED[r])
            send_command(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].want);
        wait_drained();

        // Random part in four idling phases. Phase 0 stays in one process with a
        // pool of six pages, so two leftover slots age until they saturate, and it
        // opens with a long receiver hold-off that backs the core up to its input.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
                default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
            endcase
            if (ph == 0) begin
                map_pct = 80; unmap_pct = 15; switch_pct = 0; span = 6; wide_pct = 0;
                hold_left = HOLD_OFF;
            end else begin
                map_pct = 55; unmap_pct = 20; switch_pct = 15; wide_pct = 25;
                span = (ph == 3) ? 12 : 24;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = random_command(map_pct, unmap_pct, switch_pct, span, wide_pct);
                send_command(cmd, 1'b0, '0);
                sender_gap();
            end
            wait_drained();
        end

        // Everything has come back; keep clocking before closing so that any stray
        // transaction would still show.
        repeat (20) @(posedge i_clk);

        $display("covered %0d results: %0d maps, %0d unmaps, %0d switches, %0d no-ops",
                 results_seen, op_count[OP_MAP], op_count[OP_UNMAP],
                 op_count[OP_SWITCH], op_count[OP_NONE]);
        $display("with %0d evictions, %0d ages saturated, %0d mismatches",
                 evictions, age_saturated, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/tfmu_pkg.sv
sv/tfmu_front.sv
sv/tfmu_queue.sv
sv/tfmu_back.sv
sv/tlb_fifo_map_unmap_core.sv
tb/tlb_fifo_map_unmap_core_test.sv
